FILE: hdl/rrs_pkg.sv
// package for the round-robin cpu scheduler
// holds commands, stream word layouts and the sequencer state type
// no dependencies
`default_nettype none

package rrs_pkg;

	localparam int TASK_IDX_W = 3;
	localparam int SVC_W      = 16;
	localparam int OUT_TIME_W = 20;
	localparam int QUANTUM_W  = 8;
	localparam int CMD_W      = 2;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd5;

	localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

	// input word, lowest bits first: task_index, arrival, burst, zero fill
	typedef struct packed {
		logic [4:0]            fill;
		logic [SVC_W-1:0]      burst;
		logic [SVC_W-1:0]      arrival;
		logic [TASK_IDX_W-1:0] task_index;
	} in_data_t;

	// result word, lowest bits first: run_task, slice_start, slice_end,
	// left_over, response, turnaround, waiting, zero fill
	typedef struct packed {
		logic                  fill;
		logic [OUT_TIME_W-1:0] waiting;
		logic [OUT_TIME_W-1:0] turnaround;
		logic [OUT_TIME_W-1:0] response;
		logic [SVC_W-1:0]      left_over;
		logic [OUT_TIME_W-1:0] slice_end;
		logic [OUT_TIME_W-1:0] slice_start;
		logic [TASK_IDX_W-1:0] run_task;
	} out_data_t;

	// result flags, lowest bit first: idle, finished, all_done
	typedef struct packed {
		logic all_done;
		logic finished;
		logic idle;
	} out_user_t;

	localparam int IN_DATA_W  = $bits(in_data_t);
	localparam int OUT_DATA_W = $bits(out_data_t);
	localparam int OUT_USER_W = $bits(out_user_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP,
		ST_FETCH,
		ST_EXEC,
		ST_STAT,
		ST_SEND
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/rrs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/round_robin_cpu_scheduler.sv
// round-robin cpu scheduler with a programmable quantum, top level
// depends on rrs_pkg and rrs_ram (task table memory and ready ring memory)
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tuser cmd, tdata task word
// m_axis    out        m_axis_tvalid/tready      tdata slice word, tuser flags
// cfg       in         cfg_we                    cfg_wdata quantum
//
// load and clear are done while idle; cmd 3 is accepted and dropped
// a dispatch scans, then pops, fetches, executes, builds stats and sends; an idle
// or all_done result is sent from the pop; the scan reads one task table slot a cycle
// reset clears flags, ring pointers and time; table memories hold no reset
// a waiting result does not block loads; a dispatch stalls only to deliver
`default_nettype none

module round_robin_cpu_scheduler #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// task_index, arrival, burst
	input  wire logic [rrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  wire logic [rrs_pkg::CMD_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// run_task, slice_start, slice_end, left_over, response, turnaround, waiting
	output logic      [rrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// idle, finished, all_done
	output logic      [rrs_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [rrs_pkg::QUANTUM_W-1:0]  cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int DW    = (TIME_BITS > rrs_pkg::SVC_W) ? TIME_BITS : rrs_pkg::SVC_W;
	localparam int SUM_W = DW + 1;

	typedef struct packed {
		logic [TIME_BITS-1:0]          first_start;
		logic [rrs_pkg::SVC_W-1:0]     remaining;
		logic [rrs_pkg::SVC_W-1:0]     burst;
		logic [rrs_pkg::SVC_W-1:0]     arrival;
	} task_word_t;

	localparam int TASK_W = $bits(task_word_t);

	function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(MAX_TASKS - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] diff0(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW-1:0] r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	function automatic logic [rrs_pkg::OUT_TIME_W-1:0] out_time(input logic [DW-1:0] x);
		logic [31:0] w;
		w = 32'(x);
		return w[rrs_pkg::OUT_TIME_W-1:0];
	endfunction

	// control state
	rrs_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]              scan_cnt_q;
	logic [TIME_BITS-1:0]          now_q;
	logic [rrs_pkg::QUANTUM_W-1:0] quantum_q;
	logic [MAX_TASKS-1:0]          valid_q, started_q, queued_q, done_q;
	logic [IDX_W-1:0]              head_q, tail_q;
	logic [CNT_W-1:0]              count_q;
	logic                          out_valid_q;

	// payload registers
	logic [IDX_W-1:0]              scan_idx_s1;
	logic [IDX_W-1:0]              run_idx_s1;
	logic [TIME_BITS-1:0]          start_s2;
	logic [rrs_pkg::SVC_W-1:0]     rem_s2, arr_s2, burst_s2;
	logic [TIME_BITS-1:0]          fs_s2;
	logic                          fin_s2;
	logic [DW-1:0]                 tat_s3, resp_s3;
	rrs_pkg::out_data_t            out_q;
	rrs_pkg::out_user_t            out_user_q;

	// memory ports
	logic                          task_we;
	logic [IDX_W-1:0]              task_wa, task_ra;
	task_word_t                    task_wd, task_rd;
	logic                          ring_we;
	logic [IDX_W-1:0]              ring_wa, ring_ra, ring_rd;
	logic [IDX_W-1:0]              ring_wd;

	rrs_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_task_ram (
		.clk   (clk),
		.we    (task_we),
		.waddr (task_wa),
		.wdata (task_wd),
		.raddr (task_ra),
		.rdata (task_rd)
	);

	rrs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_wa),
		.wdata (ring_wd),
		.raddr (ring_ra),
		.rdata (ring_rd)
	);

	rrs_pkg::in_data_t in_d;
	assign in_d = rrs_pkg::in_data_t'(s_axis_tdata);

	logic                          in_acc;
	logic                          load_ok;
	logic [IDX_W-1:0]              load_idx;
	logic                          pending;
	logic                          out_free;
	logic                          scan_eval;
	logic                          scan_push;
	logic [rrs_pkg::QUANTUM_W-1:0] q_eff;
	logic [rrs_pkg::SVC_W-1:0]     run_len, rem_new;
	logic [SUM_W-1:0]              now_sum;
	logic [TIME_BITS-1:0]          now_run, now_tick;
	logic [TIME_BITS-1:0]          fs_new;
	logic                          res_load;
	rrs_pkg::out_data_t            res_d;
	rrs_pkg::out_user_t            res_user_d;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign load_ok   = 32'(in_d.task_index) < MAX_TASKS;
	assign load_idx  = IDX_W'(in_d.task_index);
	assign pending   = |(valid_q & ~done_q);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign scan_eval = (state_q == rrs_pkg::ST_SCAN) && (scan_cnt_q != '0);
	assign scan_push = scan_eval && valid_q[scan_idx_s1] && !done_q[scan_idx_s1] &&
		!queued_q[scan_idx_s1] && (DW'(task_rd.arrival) <= DW'(now_q)) &&
		(task_rd.remaining != '0) && (count_q < CNT_W'(MAX_TASKS));

	// slice arithmetic on the fetched task word
	assign q_eff   = (quantum_q == '0) ? rrs_pkg::QUANTUM_W'(1) : quantum_q;
	assign run_len = (task_rd.remaining < rrs_pkg::SVC_W'(q_eff)) ?
		task_rd.remaining : rrs_pkg::SVC_W'(q_eff);
	assign rem_new = task_rd.remaining - run_len;
	assign now_sum = SUM_W'(now_q) + SUM_W'(run_len);
	assign now_run = (now_sum[SUM_W-1:TIME_BITS] != '0) ? '1 : now_sum[TIME_BITS-1:0];
	assign now_tick = (now_q == '1) ? now_q : now_q + 1'b1;
	assign fs_new  = started_q[run_idx_s1] ? task_rd.first_start : now_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrs_pkg::ST_IDLE: begin
				if (in_acc && s_axis_tuser == rrs_pkg::CMD_DISPATCH) begin
					state_d = rrs_pkg::ST_SCAN;
				end
			end
			rrs_pkg::ST_SCAN: begin
				if (scan_cnt_q == CNT_W'(MAX_TASKS)) begin
					state_d = rrs_pkg::ST_POP;
				end
			end
			rrs_pkg::ST_POP: begin
				if (!pending || count_q == '0) begin
					if (out_free) begin
						state_d = rrs_pkg::ST_IDLE;
					end
				end else begin
					state_d = rrs_pkg::ST_FETCH;
				end
			end
			rrs_pkg::ST_FETCH: state_d = rrs_pkg::ST_EXEC;
			rrs_pkg::ST_EXEC:  state_d = rrs_pkg::ST_STAT;
			rrs_pkg::ST_STAT:  state_d = rrs_pkg::ST_SEND;
			rrs_pkg::ST_SEND: begin
				if (out_free) begin
					state_d = rrs_pkg::ST_IDLE;
				end
			end
			default: state_d = rrs_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and result word
	always_comb begin
		s_axis_tready = 1'b0;
		task_we    = 1'b0;
		task_wa    = load_idx;
		task_wd    = '{first_start: '0, remaining: in_d.burst, burst: in_d.burst,
			arrival: in_d.arrival};
		task_ra    = scan_cnt_q[IDX_W-1:0];
		ring_we    = 1'b0;
		ring_wa    = tail_q;
		ring_wd    = scan_idx_s1;
		ring_ra    = head_q;
		res_load   = 1'b0;
		res_d      = '0;
		res_user_d = '0;
		case (state_q)
			rrs_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				task_we = in_acc && s_axis_tuser == rrs_pkg::CMD_LOAD && load_ok;
			end
			rrs_pkg::ST_SCAN: begin
				ring_we = scan_push;
			end
			rrs_pkg::ST_POP: begin
				res_d.slice_start = out_time(DW'(now_q));
				if (!pending) begin
					res_load = out_free;
					res_d.slice_end = out_time(DW'(now_q));
					res_user_d.all_done = 1'b1;
				end else if (count_q == '0) begin
					res_load = out_free;
					res_d.slice_end = out_time(DW'(now_tick));
					res_user_d.idle = 1'b1;
				end
			end
			rrs_pkg::ST_FETCH: begin
				task_ra = ring_rd;
			end
			rrs_pkg::ST_EXEC: begin
				task_we = 1'b1;
				task_wa = run_idx_s1;
				task_wd = '{first_start: fs_new, remaining: rem_new,
					burst: task_rd.burst, arrival: task_rd.arrival};
				ring_we = (rem_new != '0);
				ring_wd = run_idx_s1;
			end
			rrs_pkg::ST_STAT: begin
			end
			rrs_pkg::ST_SEND: begin
				res_load = out_free;
				res_d.run_task    = rrs_pkg::TASK_IDX_W'(run_idx_s1);
				res_d.slice_start = out_time(DW'(start_s2));
				res_d.slice_end   = out_time(DW'(now_q));
				res_d.left_over   = rem_s2;
				res_user_d.finished = fin_s2;
				if (fin_s2) begin
					res_d.response   = out_time(resp_s3);
					res_d.turnaround = out_time(tat_s3);
					res_d.waiting    = out_time(diff0(tat_s3, DW'(burst_s2)));
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrs_pkg::ST_IDLE;
			scan_cnt_q  <= '0;
			now_q       <= '0;
			quantum_q   <= rrs_pkg::QUANTUM_RESET;
			valid_q     <= '0;
			started_q   <= '0;
			queued_q    <= '0;
			done_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rrs_pkg::ST_IDLE: begin
					scan_cnt_q <= '0;
					if (in_acc && s_axis_tuser == rrs_pkg::CMD_LOAD && load_ok) begin
						valid_q[load_idx]   <= 1'b1;
						started_q[load_idx] <= 1'b0;
						done_q[load_idx]    <= (in_d.burst == '0);
					end
					if (in_acc && s_axis_tuser == rrs_pkg::CMD_CLEAR) begin
						valid_q   <= '0;
						started_q <= '0;
						queued_q  <= '0;
						done_q    <= '0;
						head_q    <= '0;
						tail_q    <= '0;
						count_q   <= '0;
						now_q     <= '0;
					end
				end
				rrs_pkg::ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_push) begin
						queued_q[scan_idx_s1] <= 1'b1;
						tail_q  <= next_ptr(tail_q);
						count_q <= count_q + 1'b1;
					end
				end
				rrs_pkg::ST_POP: begin
					if (pending && count_q == '0 && out_free) begin
						now_q <= now_tick;
					end else if (pending && count_q != '0) begin
						head_q  <= next_ptr(head_q);
						count_q <= count_q - 1'b1;
					end
				end
				rrs_pkg::ST_FETCH: begin
					queued_q[ring_rd] <= 1'b0;
				end
				rrs_pkg::ST_EXEC: begin
					now_q <= now_run;
					started_q[run_idx_s1] <= 1'b1;
					if (rem_new == '0) begin
						done_q[run_idx_s1] <= 1'b1;
					end else begin
						queued_q[run_idx_s1] <= 1'b1;
						tail_q  <= next_ptr(tail_q);
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (state_q == rrs_pkg::ST_FETCH) begin
			run_idx_s1 <= ring_rd;
		end
		if (state_q == rrs_pkg::ST_EXEC) begin
			start_s2 <= now_q;
			rem_s2   <= rem_new;
			arr_s2   <= task_rd.arrival;
			burst_s2 <= task_rd.burst;
			fs_s2    <= fs_new;
			fin_s2   <= (rem_new == '0);
		end
		if (state_q == rrs_pkg::ST_STAT) begin
			tat_s3  <= diff0(DW'(now_q), DW'(arr_s2));
			resp_s3 <= diff0(DW'(fs_s2), DW'(arr_s2));
		end
		if (res_load) begin
			out_q      <= res_d;
			out_user_q <= res_user_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: hdl/rrs_checker.sv
// port-level checks for the round-robin cpu scheduler, bound to the top level
// depends on rrs_pkg and round_robin_cpu_scheduler
`default_nettype none

module rrs_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic [rrs_pkg::CMD_W-1:0]      s_axis_tuser,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [rrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [rrs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	rrs_pkg::out_data_t od;
	rrs_pkg::out_user_t ou;

	assign od = rrs_pkg::out_data_t'(m_axis_tdata);
	assign ou = rrs_pkg::out_user_t'(m_axis_tuser);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// a dispatch closes the input until its result is built
	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == rrs_pkg::CMD_DISPATCH |=>
			!s_axis_tready)
		else $error("input accepted during a dispatch");

	// all_done runs no slice
	a_all_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ou.all_done |->
			od.slice_start == od.slice_end && od.run_task == '0 &&
			od.left_over == '0 && !ou.idle && !ou.finished)
		else $error("all_done word carries a slice");

	// finished slice leaves nothing, and stats appear only on finish
	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ou.finished |-> od.left_over == '0 && !ou.idle && !ou.all_done)
		else $error("finished word with service left");

	a_no_stats: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !ou.finished |->
			od.response == '0 && od.turnaround == '0 && od.waiting == '0)
		else $error("timing stats on an unfinished word");

endmodule

bind round_robin_cpu_scheduler rrs_checker u_rrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for round_robin_cpu_scheduler: directed and random task words
// against a cycle-free scheduling predictor, under varying stream idling and stalls
// depends on rrs_pkg and the scheduler rtl

module tb_top;

	localparam logic [rrs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int TW = rrs_pkg::OUT_TIME_W;
	localparam logic [TW-1:0] TIME_MAX = '1;
	localparam int SLOTS = 8;
	localparam int DRAIN_CYCLES = 32;
	localparam int BATCH_WORDS = 220;

	typedef struct {
		logic [rrs_pkg::CMD_W-1:0] cmd;
		rrs_pkg::in_data_t         data;
	} task_word_t;

	typedef struct packed {
		rrs_pkg::out_user_t flags;
		rrs_pkg::out_data_t data;
	} slice_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [rrs_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [rrs_pkg::CMD_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [rrs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [rrs_pkg::OUT_USER_W-1:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [rrs_pkg::QUANTUM_W-1:0] cfg_wdata = '0;

	task_word_t words_to_send[$];
	slice_word_t slices_due[$];
	task_word_t offered;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mismatches = 0;

	// scheduler image kept by the bench
	logic [rrs_pkg::QUANTUM_W-1:0] quantum_now = rrs_pkg::QUANTUM_RESET;
	logic [rrs_pkg::SVC_W-1:0] arrival_of [SLOTS];
	logic [rrs_pkg::SVC_W-1:0] burst_of [SLOTS];
	logic [rrs_pkg::SVC_W-1:0] left_of [SLOTS];
	logic [TW-1:0] first_run_of [SLOTS];
	bit slot_valid [SLOTS];
	bit slot_started [SLOTS];
	bit slot_queued [SLOTS];
	bit slot_done [SLOTS];
	logic [rrs_pkg::TASK_IDX_W-1:0] ready_q [SLOTS];
	logic [rrs_pkg::TASK_IDX_W-1:0] ready_head;
	logic [rrs_pkg::TASK_IDX_W-1:0] ready_tail;
	int ready_count;
	logic [TW-1:0] sched_now;

	round_robin_cpu_scheduler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void wipe_schedule();
		for (int i = 0; i < SLOTS; i++) begin
			arrival_of[i] = '0;
			burst_of[i] = '0;
			left_of[i] = '0;
			first_run_of[i] = '0;
			slot_valid[i] = 0;
			slot_started[i] = 0;
			slot_queued[i] = 0;
			slot_done[i] = 0;
			ready_q[i] = '0;
		end
		ready_head = '0;
		ready_tail = '0;
		ready_count = 0;
		sched_now = '0;
	endfunction

	function automatic void ready_push(input logic [rrs_pkg::TASK_IDX_W-1:0] t);
		if (ready_count < SLOTS) begin
			ready_q[ready_tail] = t;
			ready_tail = ready_tail + 1'b1;
			ready_count++;
			slot_queued[t] = 1;
		end
	endfunction

	function automatic logic [TW-1:0] floor_diff(input logic [TW-1:0] a,
			input logic [TW-1:0] b);
		return (a >= b) ? a - b : '0;
	endfunction

	// one accepted word: update the image and queue the slice it yields
	function automatic void schedule_word(input logic [rrs_pkg::CMD_W-1:0] cmd,
			input rrs_pkg::in_data_t w);
		slice_word_t r;
		logic [rrs_pkg::TASK_IDX_W-1:0] t;
		logic [rrs_pkg::SVC_W-1:0] q;
		logic [rrs_pkg::SVC_W-1:0] run;
		logic [rrs_pkg::SVC_W-1:0] rem;
		logic [TW:0] sum;
		logic [TW-1:0] tat;
		bit pending;
		r = '0;
		pending = 0;
		case (cmd)
			rrs_pkg::CMD_LOAD: begin
				t = w.task_index;
				arrival_of[t] = w.arrival;
				burst_of[t] = w.burst;
				left_of[t] = w.burst;
				first_run_of[t] = '0;
				slot_valid[t] = 1;
				slot_started[t] = 0;
				slot_done[t] = (w.burst == '0);
			end
			rrs_pkg::CMD_CLEAR: begin
				wipe_schedule();
			end
			rrs_pkg::CMD_DISPATCH: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_valid[i] && !slot_done[i])
						pending = 1;
				if (!pending) begin
					r.data.slice_start = sched_now;
					r.data.slice_end = sched_now;
					r.flags.all_done = 1'b1;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i] && !slot_done[i] && !slot_queued[i] &&
								TW'(arrival_of[i]) <= sched_now && left_of[i] != '0)
							ready_push(rrs_pkg::TASK_IDX_W'(i));
					if (ready_count == 0) begin
						r.data.slice_start = sched_now;
						if (sched_now != TIME_MAX)
							sched_now = sched_now + 1'b1;
						r.data.slice_end = sched_now;
						r.flags.idle = 1'b1;
					end else begin
						t = ready_q[ready_head];
						ready_head = ready_head + 1'b1;
						ready_count--;
						slot_queued[t] = 0;
						q = (quantum_now == '0) ? rrs_pkg::SVC_W'(1) :
							rrs_pkg::SVC_W'(quantum_now);
						rem = left_of[t];
						run = (rem < q) ? rem : q;
						if (!slot_started[t]) begin
							slot_started[t] = 1;
							first_run_of[t] = sched_now;
						end
						r.data.slice_start = sched_now;
						sum = {1'b0, sched_now} + (TW + 1)'(run);
						sched_now = (sum > (TW + 1)'(TIME_MAX)) ? TIME_MAX : sum[TW-1:0];
						rem = rem - run;
						left_of[t] = rem;
						r.data.run_task = t;
						r.data.slice_end = sched_now;
						r.data.left_over = rem;
						if (rem == '0) begin
							slot_done[t] = 1;
							tat = floor_diff(sched_now, TW'(arrival_of[t]));
							r.flags.finished = 1'b1;
							r.data.response = floor_diff(first_run_of[t], TW'(arrival_of[t]));
							r.data.turnaround = tat;
							r.data.waiting = floor_diff(tat, TW'(burst_of[t]));
						end else begin
							ready_push(t);
						end
					end
				end
				slices_due.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [TW-1:0] want,
			input logic [TW-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d got %0d at %0t", name, want, got, $realtime);
		end
	endfunction

	// sender side
	always @(posedge clk) begin : feeder
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			wipe_schedule();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				schedule_word(offered.cmd, offered.data);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = words_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= offered.data;
					s_axis_tuser <= offered.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure, with an optional long hold-off
	always @(posedge clk) begin : sink_ready
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : slice_monitor
		slice_word_t want;
		rrs_pkg::out_data_t got_d;
		rrs_pkg::out_user_t got_u;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_d = m_axis_tdata;
			got_u = m_axis_tuser;
			if (slices_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected slice word %h / %h at %0t", got_d, got_u, $realtime);
			end else begin
				want = slices_due.pop_front();
				check_field("run_task", TW'(want.data.run_task), TW'(got_d.run_task));
				check_field("slice_start", want.data.slice_start, got_d.slice_start);
				check_field("slice_end", want.data.slice_end, got_d.slice_end);
				check_field("left_over", TW'(want.data.left_over), TW'(got_d.left_over));
				check_field("response", want.data.response, got_d.response);
				check_field("turnaround", want.data.turnaround, got_d.turnaround);
				check_field("waiting", want.data.waiting, got_d.waiting);
				check_field("idle", TW'(want.flags.idle), TW'(got_u.idle));
				check_field("finished", TW'(want.flags.finished), TW'(got_u.finished));
				check_field("all_done", TW'(want.flags.all_done), TW'(got_u.all_done));
			end
		end
	end

	task automatic queue_word(input logic [rrs_pkg::CMD_W-1:0] cmd, input int unsigned idx,
			input int unsigned arr, input int unsigned bur);
		task_word_t w;
		w.cmd = cmd;
		w.data = '0;
		w.data.task_index = rrs_pkg::TASK_IDX_W'(idx);
		w.data.arrival = rrs_pkg::SVC_W'(arr);
		w.data.burst = rrs_pkg::SVC_W'(bur);
		words_to_send.push_back(w);
	endtask

	task automatic wait_drained();
		while (words_to_send.size() != 0 || s_axis_tvalid || slices_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_quantum(input logic [rrs_pkg::QUANTUM_W-1:0] q);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum_now = q;
	endtask

	// mostly load-then-dispatch runs, with stray words mixed in
	task automatic queue_random_batch(input int n_words);
		int sent;
		int pick;
		int n_disp;
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				queue_word(CMD_UNUSED, $urandom, $urandom, $urandom);
			end else if (pick < 12) begin
				queue_word(rrs_pkg::CMD_LOAD, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 16) begin
				queue_word(rrs_pkg::CMD_DISPATCH, $urandom, $urandom, $urandom);
				sent++;
			end else begin
				if ($urandom_range(1) == 1) begin
					queue_word(rrs_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
					sent++;
				end
				repeat ($urandom_range(1, 8)) begin
					pick = $urandom_range(99);
					queue_word(rrs_pkg::CMD_LOAD, $urandom_range(7),
						($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40),
						(pick < 5) ? 0 : (pick < 10) ? $urandom_range(65535) :
						$urandom_range(1, 30));
					sent++;
				end
				n_disp = $urandom_range(3, 40);
				repeat (n_disp) queue_word(rrs_pkg::CMD_DISPATCH, $urandom, $urandom, $urandom);
				sent += n_disp;
			end
		end
	endtask

	task automatic run_phase(input int send_pct, input int stall_pct,
			input logic [rrs_pkg::QUANTUM_W-1:0] q, input int hold);
		write_quantum(q);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		queue_random_batch(BATCH_WORDS);
		hold_request = hold;
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing loaded yet, then an ignored command
		queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		queue_word(CMD_UNUSED, 5, 'hA5A5, 'h5A5A);
		queue_word(rrs_pkg::CMD_LOAD, 7, 2, 3);
		queue_word(rrs_pkg::CMD_LOAD, 0, 0, 7);
		queue_word(rrs_pkg::CMD_LOAD, 1, 'hFFFF, 'hFFFF);
		queue_word(rrs_pkg::CMD_LOAD, 2, 0, 0);
		// preemption, late arrival, then an idle slot
		repeat (4) queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		// reload of a queued slot, first with service left, then with none
		queue_word(rrs_pkg::CMD_LOAD, 3, 0, 20);
		queue_word(rrs_pkg::CMD_DISPATCH, 7, 'hFFFF, 'hFFFF);
		queue_word(rrs_pkg::CMD_LOAD, 3, 4, 9);
		queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		queue_word(rrs_pkg::CMD_LOAD, 3, 0, 0);
		queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		queue_word(rrs_pkg::CMD_CLEAR, 7, 'hFFFF, 'hFFFF);
		queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		wait_drained();

		run_phase(0, 0, 8'd3, 300);
		run_phase(67, 0, 8'd0, 0);
		run_phase(0, 67, 8'd255, 0);
		run_phase(15, 15, rrs_pkg::QUANTUM_W'($urandom_range(2, 16)), 0);

		// full-size tasks at the widest quantum
		write_quantum(8'd255);
		@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int unsigned s = 0; s < SLOTS; s++)
			queue_word(rrs_pkg::CMD_LOAD, s, $urandom_range(600), 'hFFFF);
		repeat (40) queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		queue_word(rrs_pkg::CMD_CLEAR, 0, 0, 0);
		queue_word(rrs_pkg::CMD_DISPATCH, 0, 0, 0);
		wait_drained();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
